@@ hw/rtl/jse_pkg.sv @@
// Shared constants and handshake types of the Jacobi eigensolver.
package jse_pkg;

	localparam int ORDER_MAX = 4;
	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 24;
	localparam int CS_BITS   = 30;
	localparam int SQ_SHIFT  = 16;
	localparam int IDX_W     = $clog2(ORDER_MAX);
	localparam int CELL_W    = 2 * IDX_W;
	localparam int ADDR_W    = CELL_W + 1;

	localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(64'sd1 <<< FRAC_W);

	// Start request to the rotation coefficient unit.
	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] app;
		logic signed [DATA_W-1:0] aqq;
		logic signed [DATA_W-1:0] apq;
	} coef_req_t;

	// Cosine and sine in Q1.30, valid with the done pulse.
	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] c;
		logic signed [DATA_W-1:0] s;
	} coef_rsp_t;

endpackage

@@ hw/rtl/jse_coef.sv @@
// Rotation coefficient unit: normalization, iterative square root and division.
module jse_coef import jse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  coef_req_t req,
	output coef_rsp_t rsp
);

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_NORM = 3'd1;
	localparam logic [2:0] C_SQX  = 3'd2;
	localparam logic [2:0] C_SQY  = 3'd3;
	localparam logic [2:0] C_ROOT = 3'd4;
	localparam logic [2:0] C_DIV  = 3'd5;
	localparam logic [2:0] C_TSQ  = 3'd6;
	localparam logic [2:0] C_SM   = 3'd7;

	logic [2:0]  st_q;
	logic        second_q;
	logic [32:0] x_q;
	logic [31:0] y_q;
	logic        pos_q;
	logic [63:0] sum_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [61:0] num_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic [30:0] tm_q;
	logic [30:0] c_q;
	logic        done_q;
	logic signed [DATA_W-1:0] cout_q;
	logic signed [DATA_W-1:0] sout_q;

	logic [30:0] mul_a;
	logic [30:0] mul_b;
	logic [61:0] mul_p;
	logic [32:0] diff;
	logic [32:0] xy_or;
	logic [30:0] yy;
	logic [63:0] sq_try;
	logic [63:0] res_nxt;
	logic [33:0] rem_try;
	logic        qbit;
	logic [31:0] quo_nxt;
	logic [31:0] sm;

	assign diff   = {req.aqq[DATA_W-1], req.aqq} - {req.app[DATA_W-1], req.app};
	assign xy_or  = x_q | {1'b0, y_q};
	assign yy     = {y_q[29:0], 1'b0};
	assign mul_p  = mul_a * mul_b;
	assign sq_try = res_q + bit_q;
	assign res_nxt = (sum_q >= sq_try) ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	assign rem_try = {rem_q[32:0], num_q[61]};
	assign qbit    = (rem_try >= {1'b0, den_q});
	assign quo_nxt = {quo_q[30:0], qbit};
	assign sm      = mul_p[61:CS_BITS];

	always_comb begin
		case (st_q)
			C_SQX: begin
				mul_a = x_q[30:0];
				mul_b = x_q[30:0];
			end
			C_SQY: begin
				mul_a = yy;
				mul_b = yy;
			end
			C_TSQ: begin
				mul_a = tm_q;
				mul_b = tm_q;
			end
			C_SM: begin
				mul_a = tm_q;
				mul_b = c_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= C_IDLE;
			second_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				C_IDLE: begin
					if (req.start) begin
						second_q <= 1'b0;
						st_q     <= C_NORM;
					end
				end
				C_NORM: begin
					if (xy_or[32:30] != 3'b000) begin
					end else if (!xy_or[29]) begin
					end else begin
						st_q <= C_SQX;
					end
				end
				C_SQX: st_q <= C_SQY;
				C_SQY: st_q <= C_ROOT;
				C_ROOT: begin
					if (bit_q == 64'd1) begin
						st_q <= C_DIV;
					end
				end
				C_DIV: begin
					if (cnt_q == 6'd0) begin
						st_q <= second_q ? C_SM : C_TSQ;
					end
				end
				C_TSQ: begin
					second_q <= 1'b1;
					st_q     <= C_ROOT;
				end
				C_SM: begin
					done_q <= 1'b1;
					st_q   <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				if (req.start) begin
					x_q   <= diff[32] ? (~diff + 33'd1) : diff;
					y_q   <= req.apq[DATA_W-1] ? (~req.apq + 32'd1) : req.apq;
					pos_q <= (diff == 33'd0) || (diff[32] == req.apq[DATA_W-1]);
				end
			end
			C_NORM: begin
				if (xy_or[32:30] != 3'b000) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
				end else if (!xy_or[29]) begin
					x_q <= x_q << 1;
					y_q <= y_q << 1;
				end
			end
			C_SQX: sum_q <= 64'(mul_p);
			C_SQY: begin
				sum_q <= sum_q + 64'(mul_p);
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			C_ROOT: begin
				if (sum_q >= sq_try) begin
					sum_q <= sum_q - sq_try;
				end
				res_q <= res_nxt;
				bit_q <= bit_q >> 2;
				if (bit_q == 64'd1) begin
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 6'd61;
					if (second_q) begin
						den_q <= res_nxt[32:0];
						num_q <= 62'd1 << 60;
					end else begin
						den_q <= x_q + res_nxt[32:0];
						num_q <= {yy, 31'd0} >> 1;
					end
				end
			end
			C_DIV: begin
				rem_q <= qbit ? (rem_try - {1'b0, den_q}) : rem_try;
				num_q <= num_q << 1;
				quo_q <= quo_nxt;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					if (second_q) begin
						c_q <= quo_nxt[30:0];
					end else begin
						tm_q <= quo_nxt[30:0];
					end
				end
			end
			C_TSQ: begin
				sum_q <= 64'(mul_p) + (64'd1 << 60);
				res_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			C_SM: begin
				cout_q <= DATA_W'(c_q);
				sout_q <= pos_q ? $signed(sm) : $signed(~sm + 32'd1);
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.c    = cout_q;
	assign rsp.s    = sout_q;

endmodule

@@ hw/rtl/jacobi_symmetric_eigensolver.sv @@
// Top level of the cyclic Jacobi eigensolver: matrix store, sweep sequencer, result stream.
//
//  channel  dir  signals                      words
//  s_*      in   tvalid tready tdata[31:0]    element (Q8.24)
//  m_*      out  tvalid tready tdata[39:0]    row_index, col_index, result_value, converged
//                tuser[0] tlast               kind; tlast marks the last result of a run
//  cfg_*    in   we index[1:0] data[31:0]     matrix_size, max_sweeps, converge_limit, skip_limit
//
// Elements load one per cycle into the matrix store. After the last one, the vector store is
// set to identity, then the sweeps run from a single-port-read memory: each off-sum term is
// read, squared and summed; each rotation needs coefficient work (square roots and divisions
// one bit per cycle) plus two reads, two products and two writes per element pair, 3n pairs
// per rotation. Each result is read, then registered; loading of the next matrix starts as
// the last result is posted. Reset is asynchronous; a stalled result holds everything behind it.
module jacobi_symmetric_eigensolver import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] row_index, [3:2] col_index, [35:4] result_value,
	                               // [36] converged, [39:37] zero
	output logic [0:0]  m_tuser,   // [0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [1:0] REG_SIZE   = 2'd0;
	localparam logic [1:0] REG_SWEEPS = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;
	localparam logic [1:0] REG_SKIP   = 2'd3;

	localparam logic [4:0] ST_LOAD     = 5'd0;
	localparam logic [4:0] ST_VINIT    = 5'd1;
	localparam logic [4:0] ST_SWEEP    = 5'd2;
	localparam logic [4:0] ST_OFF_RD   = 5'd3;
	localparam logic [4:0] ST_OFF_SQ   = 5'd4;
	localparam logic [4:0] ST_OFF_ACC  = 5'd5;
	localparam logic [4:0] ST_OFF_TEST = 5'd6;
	localparam logic [4:0] ST_PAIR_RD  = 5'd7;
	localparam logic [4:0] ST_PAIR_CHK = 5'd8;
	localparam logic [4:0] ST_APP      = 5'd9;
	localparam logic [4:0] ST_AQQ      = 5'd10;
	localparam logic [4:0] ST_COEF     = 5'd11;
	localparam logic [4:0] ST_ROT_RU   = 5'd12;
	localparam logic [4:0] ST_ROT_RW   = 5'd13;
	localparam logic [4:0] ST_ROT_M1   = 5'd14;
	localparam logic [4:0] ST_ROT_M2   = 5'd15;
	localparam logic [4:0] ST_ROT_M3   = 5'd16;
	localparam logic [4:0] ST_ROT_M4   = 5'd17;
	localparam logic [4:0] ST_OUT_RD   = 5'd18;
	localparam logic [4:0] ST_OUT_LD   = 5'd19;

	localparam logic [1:0] PH_COL = 2'd0;
	localparam logic [1:0] PH_ROW = 2'd1;
	localparam logic [1:0] PH_VEC = 2'd2;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	// Product scaled down by 2^30 with truncation toward zero.
	function automatic logic signed [33:0] shr_tz(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p[63] ? (p + ((64'sd1 <<< CS_BITS) - 64'sd1)) : p;
		t = t >>> CS_BITS;
		return t[33:0];
	endfunction

	function automatic logic signed [31:0] lin(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [31:0] x;
		logic signed [31:0] y;
		x = sat32(35'(shr_tz(a)));
		y = sat32(35'(shr_tz(b)));
		return sat32(35'(x) + 35'(y));
	endfunction

	// Configuration
	logic [2:0]  size_q;
	logic [7:0]  max_sweeps_q;
	logic [31:0] limit_q;
	logic [15:0] skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q       <= 3'd4;
			max_sweeps_q <= 8'd100;
			limit_q      <= 32'd1;
			skip_q       <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE:   size_q       <= cfg_data[2:0];
				REG_SWEEPS: max_sweeps_q <= cfg_data[7:0];
				REG_LIMIT:  limit_q      <= cfg_data;
				REG_SKIP:   skip_q       <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	logic [2:0]       n_w;
	logic [IDX_W-1:0] nm1;

	always_comb begin
		if (size_q == 3'd0) begin
			n_w = 3'd1;
		end else if (size_q > 3'(ORDER_MAX)) begin
			n_w = 3'(ORDER_MAX);
		end else begin
			n_w = size_q;
		end
	end
	assign nm1 = IDX_W'(n_w - 3'd1);

	// Sequencer state
	logic [4:0]  state_q;
	logic [3:0]  lc_q;
	logic [3:0]  vi_q;
	logic [7:0]  sweep_cnt_q;
	logic [IDX_W-1:0] p_q, q_q, k_q;
	logic [1:0]  phase_q;
	logic        conv_q;
	logic [49:0] acc_q;
	logic        out_kind_q;
	logic [IDX_W-1:0] out_i_q, out_j_q;

	// Payload registers
	logic signed [31:0] apq_q, app_q, u_q, w_q, newu_q, neww_q, c_q, s_q;
	logic signed [63:0] mul1_s1, mul2_s1;
	logic signed [31:0] mul1_a, mul1_b, mul2_a, mul2_b;

	// Output register
	logic        out_valid_q;
	logic        o_kind_q, o_conv_q, o_last_q;
	logic [1:0]  o_row_q, o_col_q;
	logic [31:0] o_val_q;

	// Matrix store: work matrix in the lower half, vector matrix in the upper half.
	logic signed [31:0] mem [2*ORDER_MAX*ORDER_MAX];
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	logic signed [31:0] mem_wdata;
	logic signed [31:0] mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	coef_req_t coef_req;
	coef_rsp_t coef_rsp;

	jse_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (coef_req),
		.rsp    (coef_rsp)
	);

	assign coef_req.start = (state_q == ST_AQQ);
	assign coef_req.app   = app_q;
	assign coef_req.aqq   = mem_rdata_q;
	assign coef_req.apq   = apq_q;

	// Load position of the incoming element under the current order.
	logic [3:0] ld_row;
	logic [1:0] ld_col;
	logic [7:0] ld_third;
	logic [4:0] nn;
	logic       ld_start;
	logic       s_acc;

	always_comb begin
		ld_third = 8'(lc_q) * 8'd11;
		case (n_w)
			3'd1: begin
				ld_row = lc_q;
				ld_col = 2'd0;
				nn     = 5'd1;
			end
			3'd2: begin
				ld_row = {1'b0, lc_q[3:1]};
				ld_col = {1'b0, lc_q[0]};
				nn     = 5'd4;
			end
			3'd3: begin
				ld_row = {1'b0, ld_third[7:5]};
				ld_col = 2'(lc_q - 4'(ld_third[7:5]) * 4'd3);
				nn     = 5'd9;
			end
			default: begin
				ld_row = {2'b00, lc_q[3:2]};
				ld_col = lc_q[1:0];
				nn     = 5'd16;
			end
		endcase
	end

	assign ld_start = ({1'b0, lc_q} + 5'd1) >= nn;
	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;

	logic        last_pair;
	logic [31:0] apq_mag;
	logic        skip_pair;
	logic [ADDR_W-1:0] addr_u, addr_w;
	logic        out_last;
	logic        out_free;

	assign last_pair = (q_q == nm1) && (p_q == nm1 - IDX_W'(1));
	assign apq_mag   = mem_rdata_q[31] ? (~mem_rdata_q + 32'd1) : mem_rdata_q;
	assign skip_pair = (mem_rdata_q == 32'sd0) || (apq_mag < {16'd0, skip_q});
	assign out_last  = out_kind_q && (out_i_q == nm1) && (out_j_q == nm1);
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		case (phase_q)
			PH_COL: begin
				addr_u = {1'b0, k_q, p_q};
				addr_w = {1'b0, k_q, q_q};
			end
			PH_ROW: begin
				addr_u = {1'b0, p_q, k_q};
				addr_w = {1'b0, q_q, k_q};
			end
			default: begin
				addr_u = {1'b1, k_q, p_q};
				addr_w = {1'b1, k_q, q_q};
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			ST_LOAD: begin
				mem_we    = s_acc && (ld_row < 4'(n_w));
				mem_waddr = {1'b0, ld_row[1:0], ld_col};
				mem_wdata = s_tdata;
			end
			ST_VINIT: begin
				mem_we    = 1'b1;
				mem_waddr = {1'b1, vi_q};
				mem_wdata = (vi_q[3:2] == vi_q[1:0]) ? ONE_Q : 32'sd0;
			end
			ST_OFF_RD:   mem_raddr = {1'b0, p_q, q_q};
			ST_PAIR_RD:  mem_raddr = {1'b0, p_q, q_q};
			ST_PAIR_CHK: mem_raddr = {1'b0, p_q, p_q};
			ST_APP:      mem_raddr = {1'b0, q_q, q_q};
			ST_ROT_RU:   mem_raddr = addr_u;
			ST_ROT_RW:   mem_raddr = addr_w;
			ST_ROT_M3: begin
				mem_we    = 1'b1;
				mem_waddr = addr_u;
				mem_wdata = newu_q;
			end
			ST_ROT_M4: begin
				mem_we    = 1'b1;
				mem_waddr = addr_w;
				mem_wdata = neww_q;
			end
			ST_OUT_RD: begin
				mem_raddr = out_kind_q ? {1'b1, out_i_q, out_j_q} : {1'b0, out_i_q, out_i_q};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_ROT_M1: begin
				mul1_a = c_q;
				mul1_b = u_q;
				mul2_a = -s_q;
				mul2_b = mem_rdata_q;
			end
			ST_ROT_M2: begin
				mul1_a = s_q;
				mul1_b = u_q;
				mul2_a = c_q;
				mul2_b = w_q;
			end
			default: begin
				mul1_a = mem_rdata_q;
				mul1_b = mem_rdata_q;
				mul2_a = '0;
				mul2_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul1_s1 <= mul1_a * mul1_b;
		mul2_s1 <= mul2_a * mul2_b;
		case (state_q)
			ST_PAIR_CHK: apq_q <= mem_rdata_q;
			ST_APP:      app_q <= mem_rdata_q;
			ST_COEF: begin
				c_q <= coef_rsp.c;
				s_q <= coef_rsp.s;
			end
			ST_ROT_RW: u_q <= mem_rdata_q;
			ST_ROT_M1: w_q <= mem_rdata_q;
			ST_ROT_M2: newu_q <= lin(mul1_s1, mul2_s1);
			ST_ROT_M3: neww_q <= lin(mul1_s1, mul2_s1);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			lc_q        <= '0;
			vi_q        <= '0;
			sweep_cnt_q <= '0;
			p_q         <= '0;
			q_q         <= '0;
			k_q         <= '0;
			phase_q     <= PH_COL;
			conv_q      <= 1'b0;
			acc_q       <= '0;
			out_kind_q  <= 1'b0;
			out_i_q     <= '0;
			out_j_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (ld_start) begin
							lc_q    <= '0;
							vi_q    <= '0;
							state_q <= ST_VINIT;
						end else begin
							lc_q <= lc_q + 4'd1;
						end
					end
				end
				ST_VINIT: begin
					vi_q <= vi_q + 4'd1;
					if (vi_q == 4'd15) begin
						sweep_cnt_q <= '0;
						state_q     <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					out_kind_q <= 1'b0;
					out_i_q    <= '0;
					out_j_q    <= '0;
					p_q        <= '0;
					q_q        <= IDX_W'(1);
					acc_q      <= '0;
					if (n_w == 3'd1) begin
						conv_q  <= 1'b1;
						state_q <= ST_OUT_RD;
					end else if (sweep_cnt_q == max_sweeps_q) begin
						conv_q  <= 1'b0;
						state_q <= ST_OUT_RD;
					end else begin
						state_q <= ST_OFF_RD;
					end
				end
				ST_OFF_RD: state_q <= ST_OFF_SQ;
				ST_OFF_SQ: state_q <= ST_OFF_ACC;
				ST_OFF_ACC: begin
					acc_q <= acc_q + 50'(mul1_s1[63:SQ_SHIFT]);
					if (last_pair) begin
						state_q <= ST_OFF_TEST;
					end else begin
						state_q <= ST_OFF_RD;
						if (q_q == nm1) begin
							p_q <= p_q + IDX_W'(1);
							q_q <= p_q + IDX_W'(2);
						end else begin
							q_q <= q_q + IDX_W'(1);
						end
					end
				end
				ST_OFF_TEST: begin
					p_q <= '0;
					q_q <= IDX_W'(1);
					if (acc_q < {18'd0, limit_q}) begin
						conv_q  <= 1'b1;
						state_q <= ST_OUT_RD;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + 8'd1;
						state_q     <= ST_PAIR_RD;
					end
				end
				ST_PAIR_RD: state_q <= ST_PAIR_CHK;
				ST_PAIR_CHK: begin
					if (skip_pair) begin
						if (last_pair) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_PAIR_RD;
							if (q_q == nm1) begin
								p_q <= p_q + IDX_W'(1);
								q_q <= p_q + IDX_W'(2);
							end else begin
								q_q <= q_q + IDX_W'(1);
							end
						end
					end else begin
						state_q <= ST_APP;
					end
				end
				ST_APP: state_q <= ST_AQQ;
				ST_AQQ: state_q <= ST_COEF;
				ST_COEF: begin
					if (coef_rsp.done) begin
						phase_q <= PH_COL;
						k_q     <= '0;
						state_q <= ST_ROT_RU;
					end
				end
				ST_ROT_RU: state_q <= ST_ROT_RW;
				ST_ROT_RW: state_q <= ST_ROT_M1;
				ST_ROT_M1: state_q <= ST_ROT_M2;
				ST_ROT_M2: state_q <= ST_ROT_M3;
				ST_ROT_M3: state_q <= ST_ROT_M4;
				ST_ROT_M4: begin
					if (k_q != nm1) begin
						k_q     <= k_q + IDX_W'(1);
						state_q <= ST_ROT_RU;
					end else if (phase_q != PH_VEC) begin
						k_q     <= '0;
						phase_q <= phase_q + 2'd1;
						state_q <= ST_ROT_RU;
					end else if (last_pair) begin
						state_q <= ST_SWEEP;
					end else begin
						state_q <= ST_PAIR_RD;
						if (q_q == nm1) begin
							p_q <= p_q + IDX_W'(1);
							q_q <= p_q + IDX_W'(2);
						end else begin
							q_q <= q_q + IDX_W'(1);
						end
					end
				end
				ST_OUT_RD: begin
					if (out_free) begin
						state_q <= ST_OUT_LD;
					end
				end
				ST_OUT_LD: begin
					out_valid_q <= 1'b1;
					if (out_last) begin
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_OUT_RD;
						if (!out_kind_q) begin
							if (out_i_q == nm1) begin
								out_kind_q <= 1'b1;
								out_i_q    <= '0;
								out_j_q    <= '0;
							end else begin
								out_i_q <= out_i_q + IDX_W'(1);
							end
						end else if (out_j_q == nm1) begin
							out_j_q <= '0;
							out_i_q <= out_i_q + IDX_W'(1);
						end else begin
							out_j_q <= out_j_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT_LD) begin
			o_kind_q <= out_kind_q;
			o_row_q  <= out_i_q;
			o_col_q  <= out_kind_q ? out_j_q : 2'd0;
			o_val_q  <= mem_rdata_q;
			o_conv_q <= conv_q;
			o_last_q <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, o_conv_q, o_val_q, o_col_q, o_row_q};
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

`ifndef SYNTH
	// Loading only touches the work matrix half of the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && mem_we) |-> !mem_waddr[ADDR_W-1])
		else $error("load wrote into the vector store");

	// The coefficient unit only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		coef_rsp.done |-> (state_q == ST_COEF))
		else $error("coefficient result arrived outside its wait state");

	// A result is only loaded when the previous word was gone or leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT_LD) |-> $past(!m_tvalid || m_tready))
		else $error("output register overwritten while stalled");
`endif

endmodule

@@ tb/tb_jacobi_symmetric_eigensolver.sv @@
// Self-checking testbench of the Jacobi eigensolver: random matrices, register settings and stalls.
`timescale 1ns / 1ps

module tb_jacobi_symmetric_eigensolver;
	import jse_pkg::*;

	typedef enum logic [1:0] {
		REG_SIZE     = 2'd0,
		REG_SWEEPS   = 2'd1,
		REG_CONVERGE = 2'd2,
		REG_SKIP     = 2'd3
	} reg_index_e;

	typedef enum logic {
		KIND_VALUE  = 1'b0,
		KIND_VECTOR = 1'b1
	} word_kind_e;

	typedef struct packed {
		logic        kind;
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        conv;
		logic        last;
	} eigen_word_t;

	localparam longint SAT_HI        = (64'sd1 <<< (DATA_W - 1)) - 1;
	localparam longint SAT_LO        = -SAT_HI - 1;
	localparam int     QUIET_LIMIT   = 1500000;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     TARGET_ITEMS  = 200;

	// Predicts the eigenvalue and eigenvector words of each completed matrix.
	class eigen_scoreboard;
		longint      amat[ORDER_MAX*ORDER_MAX];
		longint      vmat[ORDER_MAX*ORDER_MAX];
		int unsigned loaded;
		logic [2:0]  size_reg;
		logic [7:0]  sweep_cap;
		logic [31:0] conv_lim;
		logic [15:0] skip_lim;
		eigen_word_t pending_words[$];
		int          errors;
		int          matrices;
		int          words_checked;
		int          elements;

		function new();
			foreach (amat[i]) begin
				amat[i] = 0;
				vmat[i] = 0;
			end
			loaded = 0;
			size_reg = 3'd4;
			sweep_cap = 8'd100;
			conv_lim = 32'd1;
			skip_lim = 16'd1;
			errors = 0;
			matrices = 0;
			words_checked = 0;
			elements = 0;
		endfunction

		function void write_reg(reg_index_e idx, logic [31:0] data);
			case (idx)
				REG_SIZE:     size_reg = data[2:0];
				REG_SWEEPS:   sweep_cap = data[7:0];
				REG_CONVERGE: conv_lim = data;
				REG_SKIP:     skip_lim = data[15:0];
				default: ;
			endcase
		endfunction

		function int unsigned order_now();
			if (size_reg == 0) return 1;
			return (size_reg > ORDER_MAX) ? ORDER_MAX : size_reg;
		endfunction

		function logic [63:0] magnitude(longint x);
			return (x < 0) ? 64'(-x) : 64'(x);
		endfunction

		function logic [63:0] umul_shift(logic [63:0] a, logic [63:0] b, int sh);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			p = p >> sh;
			if (p[127:64] != 0) return '1;
			return p[63:0];
		endfunction

		function longint smul_shift(longint a, longint b, int sh);
			logic [63:0] r;
			r = umul_shift(magnitude(a), magnitude(b), sh);
			if ((a < 0) != (b < 0))
				return (r > 64'(SAT_HI)) ? SAT_LO : -longint'(r);
			return (r > 64'(SAT_HI)) ? SAT_HI : longint'(r);
		endfunction

		function longint sat_add(longint a, longint b);
			longint s;
			s = a + b;
			if (s > SAT_HI) return SAT_HI;
			if (s < SAT_LO) return SAT_LO;
			return s;
		endfunction

		function longint combine(longint a, longint x, longint b, longint y);
			return sat_add(smul_shift(a, x, CS_BITS), smul_shift(b, y, CS_BITS));
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function void rotate_pair(int n, int p, int q);
			longint      app, aqq, apq, ci, si, u, w;
			logic [63:0] x, y, yy, r, tm, h, c, sm;
			logic        dneg, pos;
			app = amat[p*ORDER_MAX+p];
			aqq = amat[q*ORDER_MAX+q];
			apq = amat[p*ORDER_MAX+q];
			if (aqq >= app) begin
				x = 64'(aqq - app);
				dneg = 0;
			end else begin
				x = 64'(app - aqq);
				dneg = 1;
			end
			y = magnitude(apq);
			pos = (x == 0) || (dneg == (apq < 0));
			// Normalize so the larger of the two lies in [2^29, 2^30).
			while ((x | y) >= (64'd1 << 30)) begin
				x = x >> 1;
				y = y >> 1;
			end
			while ((x | y) < (64'd1 << 29)) begin
				x = x << 1;
				y = y << 1;
			end
			yy = y << 1;
			r = int_sqrt(x * x + yy * yy);
			tm = (yy << CS_BITS) / (x + r);
			h = int_sqrt(tm * tm + (64'd1 << 60));
			c = (64'd1 << 60) / h;
			sm = (tm * c) >> CS_BITS;
			ci = longint'(c);
			si = pos ? longint'(sm) : -longint'(sm);
			for (int k = 0; k < n; k++) begin
				u = amat[k*ORDER_MAX+p];
				w = amat[k*ORDER_MAX+q];
				amat[k*ORDER_MAX+p] = combine(ci, u, -si, w);
				amat[k*ORDER_MAX+q] = combine(si, u, ci, w);
			end
			for (int k = 0; k < n; k++) begin
				u = amat[p*ORDER_MAX+k];
				w = amat[q*ORDER_MAX+k];
				amat[p*ORDER_MAX+k] = combine(ci, u, -si, w);
				amat[q*ORDER_MAX+k] = combine(si, u, ci, w);
			end
			for (int k = 0; k < n; k++) begin
				u = vmat[k*ORDER_MAX+p];
				w = vmat[k*ORDER_MAX+q];
				vmat[k*ORDER_MAX+p] = combine(ci, u, -si, w);
				vmat[k*ORDER_MAX+q] = combine(si, u, ci, w);
			end
		endfunction

		function logic run_sweeps(int n);
			logic [63:0] off, sq, a;
			longint      apq;
			for (int sw = 0; sw < sweep_cap; sw++) begin
				off = 0;
				for (int p = 0; p < n; p++)
					for (int q = p + 1; q < n; q++) begin
						a = magnitude(amat[p*ORDER_MAX+q]);
						sq = umul_shift(a, a, SQ_SHIFT);
						off = (off > ~sq) ? '1 : off + sq;
					end
				if (off < {32'd0, conv_lim}) return 1'b1;
				for (int p = 0; p < n; p++)
					for (int q = p + 1; q < n; q++) begin
						apq = amat[p*ORDER_MAX+q];
						if (apq == 0 || magnitude(apq) < {48'd0, skip_lim}) continue;
						rotate_pair(n, p, q);
					end
			end
			return 1'b0;
		endfunction

		function void note_element(logic [31:0] e);
			int unsigned n, row, col;
			logic        conv;
			eigen_word_t wd;
			n = order_now();
			elements++;
			row = loaded / n;
			col = loaded % n;
			// Elements outside the current order are dropped after a size change.
			if (row < n) amat[row*ORDER_MAX+col] = longint'($signed(e));
			if (loaded + 1 < n * n) begin
				loaded++;
				return;
			end
			loaded = 0;
			foreach (vmat[i]) vmat[i] = 0;
			for (int i = 0; i < n; i++) vmat[i*ORDER_MAX+i] = longint'(ONE_Q);
			conv = (n == 1) ? 1'b1 : run_sweeps(n);
			for (int i = 0; i < n; i++) begin
				wd = '{KIND_VALUE, 2'(i), 2'd0, 32'(amat[i*ORDER_MAX+i]), conv, 1'b0};
				pending_words.push_back(wd);
			end
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					wd = '{KIND_VECTOR, 2'(i), 2'(j), 32'(vmat[i*ORDER_MAX+j]), conv,
						(i == n - 1 && j == n - 1)};
					pending_words.push_back(wd);
				end
			matrices++;
		endfunction

		function void check_result(eigen_word_t got);
			eigen_word_t exp_w;
			words_checked++;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result word %p", $realtime, got);
				return;
			end
			exp_w = pending_words.pop_front();
			if (got != exp_w) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch expected %p actual %p", $realtime, exp_w, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	eigen_scoreboard sb;
	logic            steady;
	int              quiet_cycles;

	jacobi_symmetric_eigensolver u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 38);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result('{m_tuser[0], m_tdata[1:0], m_tdata[3:2], m_tdata[35:4],
				m_tdata[36], m_tlast});
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input logic [31:0] v);
		if (!steady) begin
			while ($urandom_range(99) < 38) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_element(v);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending_words.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_regs(input logic [2:0] size, input logic [7:0] sweeps,
		input logic [31:0] limit, input logic [15:0] skip);
		logic [31:0] vals[4];
		vals = '{{29'd0, size}, {24'd0, sweeps}, limit, {16'd0, skip}};
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			sb.write_reg(reg_index_e'(i), vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_element();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($signed($urandom) >>> $urandom_range(0, 31));
			2: return 32'($signed($urandom) >>> $urandom_range(4, 10));
			3: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	// Symmetric matrices mostly; a noisy one has independent entries.
	task automatic send_matrix(input int n, input logic noisy);
		logic [31:0] m[ORDER_MAX][ORDER_MAX];
		for (int i = 0; i < n; i++)
			for (int j = i; j < n; j++) begin
				m[i][j] = rand_element();
				m[j][i] = noisy ? rand_element() : m[i][j];
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) send_word(m[i][j]);
	endtask

	initial begin
		logic [31:0] directed[16];
		logic [2:0]  size;
		logic [7:0]  sweeps;
		logic [31:0] limit;
		logic [15:0] skip;
		int          n;
		int          phase;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SIZE;
		cfg_data = '0;
		steady = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Extremes on the diagonal, a zero pair, a tiny pair and a saturating pair.
		directed = '{32'h7FFF_FFFF, 32'h0100_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0100_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
			32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0080_0000,
			32'hFFFF_FFFF, 32'h0000_0000, 32'h0080_0000, 32'h0100_0000};
		set_regs(3'd4, 8'd100, 32'd1, 16'd1);
		foreach (directed[i]) send_word(directed[i]);
		// Equal diagonal entries make the rotation angle's difference term zero.
		set_regs(3'd2, 8'd0, 32'd1, 16'd0);
		send_word(32'h0200_0000); send_word(32'h0100_0000);
		send_word(32'h0100_0000); send_word(32'h0200_0000);
		set_regs(3'd2, 8'd8, 32'd0, 16'd0);
		send_word(32'h0200_0000); send_word(32'h0100_0000);
		send_word(32'h0100_0000); send_word(32'h0200_0000);
		set_regs(3'd1, 8'd1, 32'd1, 16'd1);
		send_word(32'h8000_0000);
		set_regs(3'd0, 8'd5, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(32'h1234_5678);
		// Shrink the order in the middle of a load.
		set_regs(3'd4, 8'd10, 32'd1, 16'd1);
		for (int i = 0; i < 5; i++) send_word(rand_element());
		set_regs(3'd2, 8'd10, 32'd1, 16'd1);
		send_word(rand_element());
		set_regs(3'd2, 8'd255, 32'd0, 16'd0);
		send_matrix(2, 1'b0);

		phase = 0;
		while (sb.elements < TARGET_ITEMS - 24) begin
			case ($urandom_range(0, 9))
				0: size = 3'd0;
				1: size = 3'($urandom_range(5, 7));
				default: size = 3'($urandom_range(1, 4));
			endcase
			sweeps = 8'($urandom_range(1, 16));
			if ($urandom_range(0, 9) == 0) sweeps = 8'd0;
			case ($urandom_range(0, 4))
				0: limit = 32'd0;
				1: limit = 32'hFFFF_FFFF;
				2: limit = $urandom;
				3: limit = 32'($urandom_range(0, 65535));
				default: limit = 32'd1;
			endcase
			case ($urandom_range(0, 3))
				0: skip = 16'd0;
				1: skip = 16'hFFFF;
				2: skip = 16'($urandom);
				default: skip = 16'd1;
			endcase
			set_regs(size, sweeps, limit, skip);
			n = (size == 0) ? 1 : ((size > ORDER_MAX) ? ORDER_MAX : size);
			steady = (phase >= 4 && phase < 8);
			for (int k = $urandom_range(1, 3); k > 0; k--)
				send_matrix(n, $urandom_range(0, 9) == 0);
			phase++;
		end

		wait_idle();
		steady = 1'b0;
		$display("Checked %0d result words from %0d matrices built from %0d elements.",
			sb.words_checked, sb.matrices, sb.elements);
		$display("Orders one to four, sweep caps up to 255, skip and convergence extremes.");
		if (sb.errors == 0 && sb.pending_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d words never arrived", sb.errors,
				sb.pending_words.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/jse_pkg.sv
hw/rtl/jse_coef.sv
hw/rtl/jacobi_symmetric_eigensolver.sv
tb/tb_jacobi_symmetric_eigensolver.sv
